[design/bmstfp_pkg.sv]
// ----------------------------------------------------------------------------
// bmstfp_pkg
// Shared constants, types and decode helpers for the battery-monitor
// telemetry frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bmstfp_pkg;

  // sync pair and trailer bytes
  localparam logic [7:0] SYNC0 = 8'h3A;
  localparam logic [7:0] SYNC1 = 8'h16;
  localparam logic [7:0] TRL0  = 8'h0D;
  localparam logic [7:0] TRL1  = 8'h0A;

  // frame ids
  localparam logic [7:0] ID_CELL  = 8'h24;
  localparam logic [7:0] ID_SUM   = 8'h2A;
  localparam logic [7:0] ID_STAT  = 8'h25;
  localparam logic [7:0] ID_EXT   = 8'h2B;
  localparam logic [7:0] ID_SHORT = 8'h10;

  // byte count holds 0 .. longest frame (36)
  localparam int unsigned CNT_W = 6;

  // frame lengths
  localparam logic [CNT_W-1:0] LEN_CELL  = 6'd36;
  localparam logic [CNT_W-1:0] LEN_STD   = 6'd32;
  localparam logic [CNT_W-1:0] LEN_SHORT = 6'd15;
  localparam logic [CNT_W-1:0] LEN_NONE  = 6'd0;

  // positions inside the frame
  localparam logic [CNT_W-1:0] POS_SYNC1 = 6'd1;
  localparam logic [CNT_W-1:0] POS_ID    = 6'd2;
  localparam logic [CNT_W-1:0] POS_BODY  = 6'd3;
  localparam logic [CNT_W-1:0] POS_CELL0 = 6'd4;

  // result item fields
  localparam int unsigned IDX_W = 4;
  localparam int unsigned VAL_W = 17;
  localparam int unsigned SUM_COUNT = 10;

  // frame_kind codes
  localparam logic KIND_SUM  = 1'b0;
  localparam logic KIND_CELL = 1'b1;

  // summary item indexes
  localparam logic [IDX_W-1:0] SIDX_PACK_MV  = 4'd0;
  localparam logic [IDX_W-1:0] SIDX_CURRENT  = 4'd1;
  localparam logic [IDX_W-1:0] SIDX_TEMP0    = 4'd2;
  localparam logic [IDX_W-1:0] SIDX_TEMP1    = 4'd3;
  localparam logic [IDX_W-1:0] SIDX_TEMP2    = 4'd4;
  localparam logic [IDX_W-1:0] SIDX_TEMP3    = 4'd5;
  localparam logic [IDX_W-1:0] SIDX_MAH      = 4'd6;
  localparam logic [IDX_W-1:0] SIDX_SOC      = 4'd7;
  localparam logic [IDX_W-1:0] SIDX_SOH      = 4'd8;
  localparam logic [IDX_W-1:0] SIDX_CYCLES   = 4'd9;

  // defaults for the top-level parameters
  localparam int unsigned BUFFER_DEPTH_DEF = 64;
  localparam int unsigned CELL_COUNT_DEF   = 14;

  // frame complete event from the receive side to the emitter
  typedef struct packed {
    logic start;
    logic kind;
  } frame_evt_t;

  // frame length for an id, zero for an unknown id
  function automatic logic [CNT_W-1:0] id_length(input logic [7:0] id);
    logic [CNT_W-1:0] len;
    unique case (id)
      ID_CELL:  len = LEN_CELL;
      ID_SUM:   len = LEN_STD;
      ID_STAT:  len = LEN_STD;
      ID_EXT:   len = LEN_STD;
      ID_SHORT: len = LEN_SHORT;
      default:  len = LEN_NONE;
    endcase
    return len;
  endfunction

  // byte position of the low byte of a summary quantity
  function automatic logic [CNT_W-1:0] sum_pos(input logic [IDX_W-1:0] idx);
    logic [CNT_W-1:0] pos;
    unique case (idx)
      SIDX_PACK_MV: pos = 6'd8;
      SIDX_CURRENT: pos = 6'd10;
      SIDX_TEMP0:   pos = 6'd12;
      SIDX_TEMP1:   pos = 6'd13;
      SIDX_TEMP2:   pos = 6'd14;
      SIDX_TEMP3:   pos = 6'd15;
      SIDX_MAH:     pos = 6'd16;
      SIDX_SOC:     pos = 6'd24;
      SIDX_SOH:     pos = 6'd25;
      SIDX_CYCLES:  pos = 6'd26;
      default:      pos = 6'd8;
    endcase
    return pos;
  endfunction

  // summary quantities that span two bytes
  function automatic logic sum_wide(input logic [IDX_W-1:0] idx);
    return (idx == SIDX_PACK_MV) || (idx == SIDX_CURRENT) || (idx == SIDX_MAH);
  endfunction

endpackage

`default_nettype wire

[design/bmstfp_frame_mem.sv]
// ----------------------------------------------------------------------------
// bmstfp_frame_mem
// Frame byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmstfp_frame_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [7:0]        wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [7:0]        rd_data_o
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[design/bmstfp_rx.sv]
// ----------------------------------------------------------------------------
// bmstfp_rx
// Receive side: sync hunt, id decode, byte count, store writes and trailer
// check. Raises a frame event when a good summary or cell frame completes.
// ----------------------------------------------------------------------------
`default_nettype none

module bmstfp_rx
  import bmstfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [7:0]       rx_byte_i,
  input  wire logic             busy_i,
  output logic                  wr_en_o,
  output logic      [CNT_W-1:0] wr_addr_o,
  output logic      [7:0]       wr_data_o,
  output frame_evt_t            evt_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       prev_q;
  logic             acc;
  logic [CNT_W-1:0] cnt_inc;
  logic             emits;

  // no new byte while the emitter reads the store
  assign in_ready_o = !busy_i;
  assign acc        = in_valid_i && in_ready_o;
  assign cnt_inc    = cnt_q + CNT_W'(1);
  assign emits      = (id_q == ID_SUM) || (id_q == ID_CELL);

  assign wr_addr_o = cnt_q;
  assign wr_data_o = rx_byte_i;

  // frame tracking; frames never exceed 36 bytes, so the store cannot fill
  always_comb begin
    cnt_d     = cnt_q;
    len_d     = len_q;
    id_d      = id_q;
    wr_en_o   = 1'b0;
    evt_o     = '0;
    if (acc) begin
      priority if (cnt_q == '0) begin
        if (rx_byte_i == SYNC0) begin
          wr_en_o = 1'b1;
          cnt_d   = cnt_inc;
        end
      end else if (cnt_q == POS_SYNC1) begin
        if (rx_byte_i == SYNC1) begin
          wr_en_o = 1'b1;
          cnt_d   = cnt_inc;
        end else begin
          cnt_d = '0;
        end
      end else if (cnt_q == POS_ID) begin
        wr_en_o = 1'b1;
        id_d    = rx_byte_i;
        len_d   = id_length(rx_byte_i);
        cnt_d   = (id_length(rx_byte_i) == LEN_NONE) ? '0 : POS_BODY;
      end else begin
        wr_en_o = 1'b1;
        if (cnt_inc == len_q) begin
          cnt_d      = '0;
          evt_o.start = (prev_q == TRL0) && (rx_byte_i == TRL1) && emits;
          evt_o.kind  = (id_q == ID_CELL) ? KIND_CELL : KIND_SUM;
        end else begin
          cnt_d = cnt_inc;
        end
      end
    end
  end

  // byte count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // frame id, length and previous byte
  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    len_q <= len_d;
    if (acc) begin
      prev_q <= rx_byte_i;
    end
  end

`ifndef SYNTHESIS
  // inside a frame body the count stays below the frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= POS_BODY) |-> (cnt_q < len_q))
    else $error("byte count ran past frame length");

  // a completed frame restarts the hunt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.start |=> (cnt_q == '0))
    else $error("byte count not cleared after frame");
`endif

endmodule

`default_nettype wire

[design/bmstfp_emit.sv]
// ----------------------------------------------------------------------------
// bmstfp_emit
// Result sequencer: walks the quantities of a finished frame, reads their
// bytes from the store and loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bmstfp_emit
  import bmstfp_pkg::*;
#(
  parameter int unsigned CELL_COUNT = CELL_COUNT_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire frame_evt_t              evt_i,
  output logic                         busy_o,
  output logic                         rd_en_o,
  output logic             [CNT_W-1:0] rd_addr_o,
  input  wire logic        [7:0]       rd_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         frame_kind_o,
  output logic             [IDX_W-1:0] item_index_o,
  output logic signed      [VAL_W-1:0] item_value_o,
  output logic                         last_item_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LO   = 4'b0010,
    ST_HI   = 4'b0100,
    ST_VAL  = 4'b1000
  } emit_state_e;

  emit_state_e      state_q, state_d;
  logic             kind_q, kind_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       lo_q;
  logic             out_valid_q;
  logic [CNT_W-1:0] pos;
  logic             wide;
  logic             last;
  logic             slot_free;
  logic             load;
  logic [7:0]       hi_byte;
  logic             sign_bit;

  // byte position and shape of the current quantity
  assign pos  = (kind_q == KIND_CELL)
              ? POS_CELL0 + CNT_W'({idx_q, 1'b0})
              : sum_pos(idx_q);
  assign wide = (kind_q == KIND_CELL) || sum_wide(idx_q);
  assign last = (kind_q == KIND_CELL)
              ? (idx_q == IDX_W'(CELL_COUNT - 1))
              : (idx_q == IDX_W'(SUM_COUNT - 1));

  assign slot_free = !out_valid_q || out_ready_i;
  assign load      = (state_q == ST_VAL) && slot_free;
  assign busy_o    = (state_q != ST_IDLE);

  // value assembly; only the current is sign-extended
  assign hi_byte  = wide ? rd_data_i : 8'h00;
  assign sign_bit = (kind_q == KIND_SUM) && (idx_q == SIDX_CURRENT) && rd_data_i[7];

  // sequencer
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    idx_d     = idx_q;
    rd_en_o   = 1'b0;
    rd_addr_o = pos;
    unique case (state_q)
      ST_IDLE: begin
        if (evt_i.start) begin
          kind_d  = evt_i.kind;
          idx_d   = '0;
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        rd_en_o = 1'b1;
        state_d = ST_HI;
      end
      ST_HI: begin
        rd_en_o   = 1'b1;
        rd_addr_o = pos + CNT_W'(1);
        state_d   = ST_VAL;
      end
      ST_VAL: begin
        if (slot_free) begin
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_LO;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item position and low byte
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    idx_q  <= idx_d;
    if (state_q == ST_HI) begin
      lo_q <= rd_data_i;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_kind_o <= kind_q;
      item_index_o <= idx_q;
      item_value_o <= $signed({sign_bit, hi_byte, lo_q});
      last_item_o  <= last;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // a frame event only arrives while the sequencer is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_i.start |-> (state_q == ST_IDLE))
    else $error("frame event while emitter busy");

  // loading the final item ends the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && last) |=> (state_q == ST_IDLE) && out_valid_o && last_item_o)
    else $error("sequence did not end on final item");

  // summary items never exceed the last summary index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (frame_kind_o == KIND_SUM)) |-> (item_index_o <= SIDX_CYCLES))
    else $error("summary index out of range");
`endif

endmodule

`default_nettype wire

[design/bms_telemetry_frame_parser.sv]
// ----------------------------------------------------------------------------
// bms_telemetry_frame_parser
// Battery-monitor telemetry frame parser: collects sync-framed byte frames in
// a byte store and emits summary quantities or cell voltages per frame.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_ready_o | rx_byte_i
//   out     | output    | out_valid_o/out_ready_i | frame_kind_o, item_index_o,
//           |           |                         | item_value_o, last_item_o
//
// A byte is taken every cycle while no frame is being emitted.
// After a good summary or cell frame, the sequencer steps through each result
// in order (low byte read, high byte read, load) for every summary quantity or
// cell, and in_ready_o stays low until the last result is loaded.
// A stalled output holds the sequencer in place; the last result of a frame
// may wait in the output register while the next frame's bytes come in.
// Reset clears the byte count and the sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_telemetry_frame_parser
  import bmstfp_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int unsigned CELL_COUNT   = CELL_COUNT_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic        [7:0]       rx_byte_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         frame_kind_o,
  output logic             [IDX_W-1:0] item_index_o,
  output logic signed      [VAL_W-1:0] item_value_o,
  output logic                         last_item_o
);

  localparam int unsigned ADDR_W = $clog2(BUFFER_DEPTH);

  logic             busy;
  logic             wr_en;
  logic [CNT_W-1:0] wr_pos;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [CNT_W-1:0] rd_pos;
  logic [7:0]       rd_data;
  frame_evt_t       evt;

  // receive side
  bmstfp_rx u_rx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .busy_i     (busy),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_pos),
    .wr_data_o  (wr_data),
    .evt_o      (evt)
  );

  // frame byte store; writes and reads never overlap since input is held
  // off while the sequencer reads
  bmstfp_frame_mem #(
    .DEPTH  (BUFFER_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (ADDR_W'(wr_pos)),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ADDR_W'(rd_pos)),
    .rd_data_o (rd_data)
  );

  // result sequencer and output register
  bmstfp_emit #(
    .CELL_COUNT (CELL_COUNT)
  ) u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .evt_i        (evt),
    .busy_o       (busy),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_pos),
    .rd_data_i    (rd_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_kind_o (frame_kind_o),
    .item_index_o (item_index_o),
    .item_value_o (item_value_o),
    .last_item_o  (last_item_o)
  );

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the telemetry frame parser: feeds a byte stream of
// sync-framed summary, cell and silent frames mixed with noise and broken
// frames, predicts every decoded quantity and cell voltage, and compares the
// results in order under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmstfp_pkg::*;

  localparam int unsigned DEPTH       = BUFFER_DEPTH_DEF;
  localparam int unsigned CELLS       = CELL_COUNT_DEF;
  localparam int unsigned MAX_FRAME   = 36;
  localparam int unsigned RAND_BYTES  = 8;
  localparam int unsigned MIN_RESULTS = 10;
  localparam int unsigned DRAIN       = 3 * CELLS + 30;
  localparam int unsigned HOLD_START  = 150;
  localparam int unsigned HOLD_LEN    = 400;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             is_last;
  } telem_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_e;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              rx_byte = 8'h00;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    frame_kind;
  logic [IDX_W-1:0]        item_index;
  logic signed [VAL_W-1:0] item_value;
  logic                    last_item;

  bms_telemetry_frame_parser #(
    .BUFFER_DEPTH(DEPTH),
    .CELL_COUNT  (CELLS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .frame_kind_o(frame_kind),
    .item_index_o(item_index),
    .item_value_o(item_value),
    .last_item_o (last_item)
  );

  // byte stream waiting to be sent and decoded values waiting to come out
  logic [7:0]  byte_queue[$];
  telem_item_t decoded_queue[$];

  // shadow of the frame collector
  logic [7:0]  frame_buf[DEPTH];
  int unsigned fill_count = 0;

  // scratch image used to build frames
  logic [7:0]  frame_img[MAX_FRAME];

  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches = 0;
  int unsigned sum_frames = 0;
  int unsigned cell_frames = 0;
  int unsigned silent_frames = 0;
  int unsigned dropped_frames = 0;
  int unsigned cycle_count = 0;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // frame length for an id, zero for ids the parser does not know
  function automatic int unsigned frame_length(input logic [7:0] id);
    case (id)
      ID_CELL:                 return LEN_CELL;
      ID_SUM, ID_STAT, ID_EXT: return LEN_STD;
      ID_SHORT:                return LEN_SHORT;
      default:                 return 0;
    endcase
  endfunction

  // collected byte, zero past the end of the store
  function automatic logic [7:0] stored_byte(input int unsigned pos);
    return (pos < DEPTH) ? frame_buf[pos] : 8'h00;
  endfunction

  function automatic logic [15:0] stored_le16(input int unsigned pos);
    return {stored_byte(pos + 1), stored_byte(pos)};
  endfunction

  task automatic push_decoded(input logic kind, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input logic is_last);
    decoded_queue.push_back('{kind: kind, index: idx, value: val, is_last: is_last});
  endtask

  // collect one byte and queue the values that a completed frame yields
  task automatic decode_rx_byte(input logic [7:0] b);
    int unsigned flen;
    logic [15:0] cur;
    logic [7:0]  id;
    if (fill_count == 0 && b != SYNC0) return;
    if (fill_count == 1 && b != SYNC1) begin
      fill_count = 0;
      return;
    end
    if (fill_count >= DEPTH) begin
      fill_count = 0;
      return;
    end
    frame_buf[fill_count] = b;
    fill_count++;
    if (fill_count < 3) return;
    id   = stored_byte(POS_ID);
    flen = frame_length(id);
    if (flen == 0) begin
      fill_count = 0;
      dropped_frames++;
      return;
    end
    if (fill_count < flen) return;
    fill_count = 0;
    if (stored_byte(flen - 2) != TRL0 || stored_byte(flen - 1) != TRL1) begin
      dropped_frames++;
      return;
    end
    if (id == ID_SUM) begin
      sum_frames++;
      cur = stored_le16(10);
      push_decoded(KIND_SUM, SIDX_PACK_MV, {1'b0, stored_le16(8)}, 1'b0);
      push_decoded(KIND_SUM, SIDX_CURRENT, {cur[15], cur}, 1'b0);
      for (int k = 0; k < 4; k++)
        push_decoded(KIND_SUM, SIDX_TEMP0 + IDX_W'(k), {9'd0, stored_byte(12 + k)}, 1'b0);
      push_decoded(KIND_SUM, SIDX_MAH, {1'b0, stored_le16(16)}, 1'b0);
      push_decoded(KIND_SUM, SIDX_SOC, {9'd0, stored_byte(24)}, 1'b0);
      push_decoded(KIND_SUM, SIDX_SOH, {9'd0, stored_byte(25)}, 1'b0);
      push_decoded(KIND_SUM, SIDX_CYCLES, {9'd0, stored_byte(26)}, 1'b1);
    end else if (id == ID_CELL) begin
      cell_frames++;
      for (int k = 0; k < CELLS; k++)
        push_decoded(KIND_CELL, IDX_W'(k), {1'b0, stored_le16(POS_CELL0 + 2 * k)},
                     k == CELLS - 1);
    end else begin
      silent_frames++;
    end
  endtask

  // frame image with sync, id, random body and a good trailer
  task automatic open_frame(input logic [7:0] id);
    int unsigned flen;
    flen = frame_length(id);
    frame_img[0] = SYNC0;
    frame_img[1] = SYNC1;
    frame_img[2] = id;
    for (int k = 3; k < MAX_FRAME; k++) frame_img[k] = 8'($urandom_range(0, 255));
    if (flen != 0) begin
      frame_img[flen - 2] = TRL0;
      frame_img[flen - 1] = TRL1;
    end
  endtask

  task automatic queue_frame(input int unsigned nbytes);
    for (int k = 0; k < nbytes; k++) byte_queue.push_back(frame_img[k]);
  endtask

  function automatic logic [7:0] any_known_id();
    case ($urandom_range(0, 4))
      0:       return ID_SUM;
      1:       return ID_CELL;
      2:       return ID_STAT;
      3:       return ID_EXT;
      default: return ID_SHORT;
    endcase
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_valid <= 1'b1;
        rx_byte  <= byte_queue.pop_front();
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern in phases, plus one long hold-off
  int unsigned rx_cycles = 0;
  int unsigned phase_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_LEN) begin
        out_ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(16, 96);
          rx_mode    = rx_mode_e'($urandom_range(0, 2));
        end else begin
          phase_left--;
        end
        case (rx_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
          default:   out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // monitor: decode accepted bytes, check accepted results in order
  telem_item_t got_item;
  telem_item_t want_item;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        decode_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got_item = '{kind: frame_kind, index: item_index, value: item_value,
                     is_last: last_item};
        results_checked++;
        if (decoded_queue.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result kind=%0d index=%0d value=%0d last=%0d",
                   $time, got_item.kind, got_item.index, $signed(got_item.value),
                   got_item.is_last);
        end else begin
          want_item = decoded_queue.pop_front();
          if (got_item !== want_item) begin
            mismatches++;
            $display("%0t: mismatch expected kind=%0d index=%0d value=%0d last=%0d, got kind=%0d index=%0d value=%0d last=%0d",
                     $time, want_item.kind, want_item.index, $signed(want_item.value),
                     want_item.is_last, got_item.kind, got_item.index,
                     $signed(got_item.value), got_item.is_last);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, decoded_queue.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // stimulus and end of test
  initial begin
    int unsigned flen;
    int unsigned total_bytes;
    int unsigned rand_start;
    int unsigned planned_results;
    int unsigned r;
    logic [7:0]  id;
    logic [7:0]  x;
    logic [15:0] v;

    // noise while hunting, including second sync and trailer bytes
    byte_queue.push_back(8'h00);
    byte_queue.push_back(8'hFF);
    byte_queue.push_back(SYNC1);
    byte_queue.push_back(TRL0);
    // repeated first sync byte fails as second sync, then a wrong second sync
    byte_queue.push_back(SYNC0);
    byte_queue.push_back(SYNC0);
    byte_queue.push_back(SYNC0);
    byte_queue.push_back(8'h17);
    // unknown id drops the partial frame
    byte_queue.push_back(SYNC0);
    byte_queue.push_back(SYNC1);
    byte_queue.push_back(8'h55);

    // summary: top pack voltage, most negative current, temperature extremes
    open_frame(ID_SUM);
    frame_img[8]  = 8'hFF; frame_img[9]  = 8'hFF;
    frame_img[10] = 8'h00; frame_img[11] = 8'h80;
    frame_img[12] = 8'h00; frame_img[13] = 8'hFF;
    frame_img[14] = 8'h80; frame_img[15] = 8'h7F;
    frame_img[16] = 8'h00; frame_img[17] = 8'h00;
    frame_img[24] = 8'hFF; frame_img[25] = 8'h00; frame_img[26] = 8'h7F;
    queue_frame(LEN_STD);
    // summary: zero pack voltage, current of minus one, full capacity
    open_frame(ID_SUM);
    frame_img[8]  = 8'h00; frame_img[9]  = 8'h00;
    frame_img[10] = 8'hFF; frame_img[11] = 8'hFF;
    frame_img[16] = 8'hFF; frame_img[17] = 8'hFF;
    frame_img[24] = 8'h00; frame_img[25] = 8'hFF; frame_img[26] = 8'hFF;
    queue_frame(LEN_STD);
    // summary: largest positive current
    open_frame(ID_SUM);
    frame_img[10] = 8'hFF; frame_img[11] = 8'h7F;
    queue_frame(LEN_STD);
    // cell frame: zero and full-scale cells, then a walking one
    open_frame(ID_CELL);
    for (int c = 0; c < CELLS; c++) begin
      v = (c < 4) ? ((c % 2) ? 16'hFFFF : 16'h0000) : (16'h0001 << (c + 2));
      frame_img[POS_CELL0 + 2 * c]     = v[7:0];
      frame_img[POS_CELL0 + 2 * c + 1] = v[15:8];
    end
    queue_frame(LEN_CELL);
    // known ids without output
    open_frame(ID_STAT);
    queue_frame(LEN_STD);
    open_frame(ID_EXT);
    queue_frame(LEN_STD);
    open_frame(ID_SHORT);
    queue_frame(LEN_SHORT);
    // bad trailers on a summary and a cell frame
    open_frame(ID_SUM);
    frame_img[30] = TRL1;
    frame_img[31] = TRL0;
    queue_frame(LEN_STD);
    open_frame(ID_CELL);
    frame_img[35] = 8'h0B;
    queue_frame(LEN_CELL);
    // cut-off summary frame swallows the start of the next frame
    open_frame(ID_SUM);
    queue_frame(13);
    open_frame(ID_CELL);
    queue_frame(LEN_CELL);

    // random part: mostly well-formed frames, some broken ones and noise
    rand_start      = byte_queue.size();
    planned_results = 0;
    while (byte_queue.size() - rand_start < RAND_BYTES || planned_results < MIN_RESULTS) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        open_frame(ID_SUM);
        queue_frame(LEN_STD);
        planned_results += SUM_COUNT;
      end else if (r < 65) begin
        open_frame(ID_CELL);
        queue_frame(LEN_CELL);
        planned_results += CELLS;
      end else if (r < 73) begin
        case ($urandom_range(0, 2))
          0:       id = ID_STAT;
          1:       id = ID_EXT;
          default: id = ID_SHORT;
        endcase
        open_frame(id);
        queue_frame(frame_length(id));
      end else if (r < 80) begin
        // corrupt one trailer byte
        id   = any_known_id();
        flen = frame_length(id);
        open_frame(id);
        x = 8'($urandom_range(1, 255));
        frame_img[flen - 2 + $urandom_range(0, 1)] ^= x;
        queue_frame(flen);
      end else if (r < 85) begin
        do x = 8'($urandom_range(0, 255)); while (frame_length(x) != 0);
        byte_queue.push_back(SYNC0);
        byte_queue.push_back(SYNC1);
        byte_queue.push_back(x);
      end else if (r < 90) begin
        do x = 8'($urandom_range(0, 255)); while (x == SYNC1);
        byte_queue.push_back(SYNC0);
        byte_queue.push_back(x);
      end else if (r < 95) begin
        id = any_known_id();
        open_frame(id);
        queue_frame($urandom_range(3, frame_length(id) - 1));
      end else begin
        repeat ($urandom_range(1, 6)) byte_queue.push_back(8'($urandom_range(0, 255)));
      end
    end
    total_bytes = byte_queue.size();

    // reset
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // wait for every byte to be taken and every result to arrive
    while (bytes_taken < total_bytes) @(posedge clk);
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("run: %0d bytes sent, %0d summary / %0d cell / %0d silent frames decoded",
             bytes_taken, sum_frames, cell_frames, silent_frames);
    $display("run: %0d frames dropped, %0d results checked, %0d mismatches",
             dropped_frames, results_checked, mismatches);
    if (mismatches == 0 && decoded_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
design/bmstfp_pkg.sv
design/bmstfp_frame_mem.sv
design/bmstfp_rx.sv
design/bmstfp_emit.sv
design/bms_telemetry_frame_parser.sv
tb/sv/tb_top.sv
